@@ design/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
// Depends on nothing; imported by spq_cell, stable_priority_queue_unit, spq_result_checker and the test.
package spq_pkg;

    localparam int SPQ_DEPTH         = 16;
    localparam int SPQ_PAYLOAD_BITS  = 32;
    localparam int SPQ_PRIORITY_BITS = 8;

    // Fixed field widths on the stream ports
    localparam int KIND_W     = 1;
    localparam int PRI_W      = 8;
    localparam int PAY_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 88;
    localparam int M_USED_W   = 86;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 1'b0,
        KIND_POP    = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Shift commands broadcast to every cell of the chain
    typedef struct packed {
        logic shift_in;   // insert: open a slot and take the new entry
        logic shift_out;  // pop: every entry moves one cell toward the front
    } t_cell_ctrl;

endpackage

@@ design/spq_cell.sv @@
// One cell of the sorted chain: holds a priority and a payload.
// Depends on spq_pkg (t_cell_ctrl).
module spq_cell #(
    parameter int PRIORITY_BITS = spq_pkg::SPQ_PRIORITY_BITS,
    parameter int PAYLOAD_BITS  = spq_pkg::SPQ_PAYLOAD_BITS
) (
    input  logic                     i_clk,
    input  spq_pkg::t_cell_ctrl      i_ctrl,
    input  logic                     i_in_use,
    input  logic                     i_prev_place,
    input  logic [PRIORITY_BITS-1:0] i_new_pri,
    input  logic [PAYLOAD_BITS-1:0]  i_new_pay,
    input  logic [PRIORITY_BITS-1:0] i_prev_pri,
    input  logic [PAYLOAD_BITS-1:0]  i_prev_pay,
    input  logic [PRIORITY_BITS-1:0] i_next_pri,
    input  logic [PAYLOAD_BITS-1:0]  i_next_pay,
    output logic                     o_place,
    output logic [PRIORITY_BITS-1:0] o_pri,
    output logic [PAYLOAD_BITS-1:0]  o_pay
);
    import spq_pkg::*;

    logic [PRIORITY_BITS-1:0] r_pri, n_pri;
    logic [PAYLOAD_BITS-1:0]  r_pay, n_pay;

    // New entry lands at or before this cell: free cell or strictly lower priority
    assign o_place = !i_in_use || (r_pri < i_new_pri);

    always_comb begin
        n_pri = r_pri;
        n_pay = r_pay;
        if (i_ctrl.shift_in) begin
            if (i_prev_place) begin
                n_pri = i_prev_pri;
                n_pay = i_prev_pay;
            end else if (o_place) begin
                n_pri = i_new_pri;
                n_pay = i_new_pay;
            end
        end else if (i_ctrl.shift_out) begin
            n_pri = i_next_pri;
            n_pay = i_next_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pri <= n_pri;
        r_pay <= n_pay;
    end

    assign o_pri = r_pri;
    assign o_pay = r_pay;

endmodule

@@ design/stable_priority_queue_unit.sv @@
// Stable priority queue: a chain of DEPTH cells kept in descending priority.
// Usage:
//   Slave channel (i_s_*) carries one operation word: tuser selects insert or
//   pop, tdata carries the priority and payload of an insert.
//   Master channel (o_m_*) returns exactly one result word per operation:
//   tuser holds the status, tdata the removed entry, the front entry after
//   the operation, an empty flag and the occupancy.
//   An insert lands behind every stored entry of equal or higher priority, so
//   ties leave in arrival order. Insert into a full queue is dropped with
//   status full; pop of an empty queue reports status empty.
// Timing:
//   The result is registered and valid in the cycle after input accept.
//   Throughput is one word per cycle unless the receiver stalls: every cell
//   compares against the new priority and shifts in the same cycle.
//   The result register frees in the cycle it is taken, so back-to-back words
//   flow while the master side keeps tready high.
// Reset and stall:
//   Synchronous active-low reset empties the queue and drops any pending
//   result. While the receiver holds tready low with a result pending,
//   o_s_tready stays low and the queue holds its contents.
module stable_priority_queue_unit #(
    parameter int DEPTH         = spq_pkg::SPQ_DEPTH,
    parameter int PAYLOAD_BITS  = spq_pkg::SPQ_PAYLOAD_BITS,
    parameter int PRIORITY_BITS = spq_pkg::SPQ_PRIORITY_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [7:0] priority_req, [39:8] payload
    input  logic [spq_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [0] kind
    input  logic [spq_pkg::KIND_W-1:0]     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] taken_priority, [39:8] taken_payload, [40] empty_res,
    // [48:41] head_priority, [80:49] head_payload, [85:81] occupancy, [87:86] zero
    output logic [spq_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // [1:0] status
    output logic [spq_pkg::STATUS_W-1:0]   o_m_tuser
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                      accept;
    logic                      is_pop;
    logic                      full;
    logic                      do_ins;
    logic                      do_pop;
    t_cell_ctrl                ctrl;
    logic [PRIORITY_BITS-1:0]  new_pri;
    logic [PAYLOAD_BITS-1:0]   new_pay;
    logic [PRI_W+PRIORITY_BITS-1:0] pri_in_ext;
    logic [PAY_W+PAYLOAD_BITS-1:0]  pay_in_ext;

    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_out_valid;
    t_status                   r_status, n_status;
    logic [M_USED_W-1:0]       r_data, n_data;

    logic [PRIORITY_BITS-1:0]  w_pri   [DEPTH];
    logic [PAYLOAD_BITS-1:0]   w_pay   [DEPTH];
    logic                      w_place [DEPTH];

    logic [PRIORITY_BITS-1:0]  taken_pri, head_pri;
    logic [PAYLOAD_BITS-1:0]   taken_pay, head_pay;
    logic [PRIORITY_BITS+PRI_W-1:0] taken_pri_ext, head_pri_ext;
    logic [PAYLOAD_BITS+PAY_W-1:0]  taken_pay_ext, head_pay_ext;
    logic [CNT_W+OCC_W-1:0]    occ_ext;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_pop     = (t_kind'(i_s_tuser) == KIND_POP);
    assign full       = (r_count == CNT_W'(DEPTH));
    assign do_ins     = accept && !is_pop && !full;
    assign do_pop     = accept && is_pop && (r_count != '0);

    assign ctrl.shift_in  = do_ins;
    assign ctrl.shift_out = do_pop;

    // Keep only the low PRIORITY_BITS / PAYLOAD_BITS of the input fields
    assign pri_in_ext = {{PRIORITY_BITS{1'b0}}, i_s_tdata[PRI_W-1:0]};
    assign pay_in_ext = {{PAYLOAD_BITS{1'b0}}, i_s_tdata[PRI_W+PAY_W-1:PRI_W]};
    assign new_pri    = pri_in_ext[PRIORITY_BITS-1:0];
    assign new_pay    = pay_in_ext[PAYLOAD_BITS-1:0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                     prev_place;
        logic [PRIORITY_BITS-1:0] prev_pri, next_pri;
        logic [PAYLOAD_BITS-1:0]  prev_pay, next_pay;

        if (g == 0) begin : g_front
            assign prev_place = 1'b0;
            assign prev_pri   = '0;
            assign prev_pay   = '0;
        end else begin : g_mid
            assign prev_place = w_place[g-1];
            assign prev_pri   = w_pri[g-1];
            assign prev_pay   = w_pay[g-1];
        end

        if (g == DEPTH - 1) begin : g_back
            assign next_pri = '0;
            assign next_pay = '0;
        end else begin : g_inner
            assign next_pri = w_pri[g+1];
            assign next_pay = w_pay[g+1];
        end

        spq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .PAYLOAD_BITS  (PAYLOAD_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_in_use     (CNT_W'(g) < r_count),
            .i_prev_place (prev_place),
            .i_new_pri    (new_pri),
            .i_new_pay    (new_pay),
            .i_prev_pri   (prev_pri),
            .i_prev_pay   (prev_pay),
            .i_next_pri   (next_pri),
            .i_next_pay   (next_pay),
            .o_place      (w_place[g]),
            .o_pri        (w_pri[g]),
            .o_pay        (w_pay[g])
        );
    end

    always_comb begin
        n_count   = r_count;
        n_status  = ST_DONE;
        taken_pri = '0;
        taken_pay = '0;
        head_pri  = w_pri[0];
        head_pay  = w_pay[0];
        if (is_pop) begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                n_count   = r_count - CNT_W'(1);
                taken_pri = w_pri[0];
                taken_pay = w_pay[0];
                head_pri  = w_pri[1];
                head_pay  = w_pay[1];
            end
        end else begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
                if (w_place[0]) begin
                    head_pri = new_pri;
                    head_pay = new_pay;
                end
            end
        end
        if (n_count == '0) begin
            head_pri = '0;
            head_pay = '0;
        end
    end

    // Fit internal widths onto the fixed result fields
    assign taken_pri_ext = {{PRI_W{1'b0}}, taken_pri};
    assign taken_pay_ext = {{PAY_W{1'b0}}, taken_pay};
    assign head_pri_ext  = {{PRI_W{1'b0}}, head_pri};
    assign head_pay_ext  = {{PAY_W{1'b0}}, head_pay};
    assign occ_ext       = {{OCC_W{1'b0}}, n_count};

    assign n_data = {occ_ext[OCC_W-1:0],
                     head_pay_ext[PAY_W-1:0],
                     head_pri_ext[PRI_W-1:0],
                     (n_count == '0),
                     taken_pay_ext[PAY_W-1:0],
                     taken_pri_ext[PRI_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_data   <= n_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, r_data};

endmodule

@@ tb/spq_result_checker.sv @@
// Result checker for stable_priority_queue_unit: watches both stream channels,
// predicts every result word from an accepted operation and compares field by field.
// Depends on spq_pkg for widths, operation kinds and status codes.
`timescale 1ns / 1ps

module spq_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // [7:0] priority_req, [39:8] payload
    input  logic [spq_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [0] kind
    input  logic [spq_pkg::KIND_W-1:0]    i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] taken_priority, [39:8] taken_payload, [40] empty_res,
    // [48:41] head_priority, [80:49] head_payload, [85:81] occupancy, [87:86] zero
    input  logic [spq_pkg::M_TDATA_W-1:0] i_m_tdata,
    // [1:0] status
    input  logic [spq_pkg::STATUS_W-1:0]  i_m_tuser,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_full_drops,
    output int                            o_empty_pops
);
    import spq_pkg::*;

    typedef struct packed {
        t_status          status;
        logic [PRI_W-1:0] taken_pri;
        logic [PAY_W-1:0] taken_pay;
        logic             empty;
        logic [PRI_W-1:0] head_pri;
        logic [PAY_W-1:0] head_pay;
        logic [OCC_W-1:0] occ;
    } t_queue_report;

    logic [PRI_W-1:0] slot_pri [SPQ_DEPTH];
    logic [PAY_W-1:0] slot_pay [SPQ_DEPTH];
    int               fill;
    t_queue_report    queue_reports_q [$];
    int               fails;
    int               full_drops;
    int               empty_pops;

    // Sorted insert behind equal priorities, pop from the front.
    task automatic apply_queue_op(t_kind kind, logic [PRI_W-1:0] pri, logic [PAY_W-1:0] pay);
        t_queue_report r;
        int            pos;
        r = '0;
        r.status = ST_DONE;
        if (kind == KIND_INSERT) begin
            if (fill >= SPQ_DEPTH) begin
                r.status = ST_FULL;
                full_drops++;
            end else begin
                pos = fill;
                for (int i = 0; i < fill; i++) begin
                    if (slot_pri[i] < pri) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = fill; i > pos; i--) begin
                    slot_pri[i] = slot_pri[i-1];
                    slot_pay[i] = slot_pay[i-1];
                end
                slot_pri[pos] = pri;
                slot_pay[pos] = pay;
                fill++;
            end
        end else if (fill == 0) begin
            r.status = ST_EMPTY;
            empty_pops++;
        end else begin
            r.taken_pri = slot_pri[0];
            r.taken_pay = slot_pay[0];
            for (int i = 1; i < fill; i++) begin
                slot_pri[i-1] = slot_pri[i];
                slot_pay[i-1] = slot_pay[i];
            end
            fill--;
        end
        r.empty = (fill == 0);
        if (fill != 0) begin
            r.head_pri = slot_pri[0];
            r.head_pay = slot_pay[0];
        end
        r.occ = fill[OCC_W-1:0];
        queue_reports_q.push_back(r);
    endtask

    task automatic check_field(string name, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_queue_report want;
        if (!i_rst_n) begin
            fill = 0;
            queue_reports_q.delete();
        end else begin
            // Take the new operation first so a zero-gap result still finds its entry.
            if (i_s_tvalid && i_s_tready) begin
                apply_queue_op(t_kind'(i_s_tuser), i_s_tdata[PRI_W-1:0],
                               i_s_tdata[PRI_W +: PAY_W]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (queue_reports_q.size() == 0) begin
                    $error("result word with no operation waiting: tdata %0h tuser %0h",
                           i_m_tdata, i_m_tuser);
                    fails++;
                end else begin
                    want = queue_reports_q.pop_front();
                    check_field("status", PAY_W'(want.status), PAY_W'(i_m_tuser));
                    check_field("taken_priority", PAY_W'(want.taken_pri),
                                PAY_W'(i_m_tdata[7:0]));
                    check_field("taken_payload", want.taken_pay, i_m_tdata[39:8]);
                    check_field("empty_res", PAY_W'(want.empty), PAY_W'(i_m_tdata[40]));
                    check_field("head_priority", PAY_W'(want.head_pri),
                                PAY_W'(i_m_tdata[48:41]));
                    check_field("head_payload", want.head_pay, i_m_tdata[80:49]);
                    check_field("occupancy", PAY_W'(want.occ), PAY_W'(i_m_tdata[85:81]));
                    check_field("pad", '0, PAY_W'(i_m_tdata[87:86]));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= queue_reports_q.size();
        o_full_drops <= full_drops;
        o_empty_pops <= empty_pops;
    end

endmodule

@@ tb/stable_priority_queue_unit_test.sv @@
// Stimulus and verdict for stable_priority_queue_unit: directed fill, drop and drain,
// then random insert/pop runs under bursty sending and receiver stalls.
// Depends on spq_pkg, stable_priority_queue_unit and spq_result_checker.
`timescale 1ns / 1ps

module stable_priority_queue_unit_test;
    import spq_pkg::*;

    localparam int  RANDOM_WORDS = 1400;
    localparam int  LONG_HOLD    = 150;
    localparam real LIMIT_NS     = 2_000_000.0;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_mode;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 long_hold_req = 1'b0;

    int fail_count;
    int pending;
    int full_drops;
    int empty_pops;
    int sent_inserts;
    int sent_pops;
    int burst_left;

    always #1 clk = ~clk;

    stable_priority_queue_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    spq_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_full_drops (full_drops),
        .o_empty_pops (empty_pops)
    );

    // Offer one word and hold it until taken; idle between bursts.
    task automatic send_word(t_kind kind, logic [PRI_W-1:0] pri, logic [PAY_W-1:0] pay);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {pay, pri};
        do @(posedge clk); while (!s_tready);
        if (kind == KIND_INSERT) sent_inserts++;
        else sent_pops++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    initial begin : receiver
        t_rx_mode mode;
        int       seg_left;
        bit       held;
        mode     = RX_OPEN;
        seg_left = 0;
        held     = 1'b0;
        forever begin
            @(posedge clk);
            // Hold off long enough for the sender to back up against a stalled result.
            if (long_hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (seg_left == 0) begin
                mode     = t_rx_mode'($urandom_range(3));
                seg_left = $urandom_range(4, 60);
            end
            seg_left--;
            case (mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(1));
                RX_SPARSE: m_tready <= ($urandom_range(3) == 0);
                default:   m_tready <= ($urandom_range(7) != 0);
            endcase
        end
    end

    initial begin : stimulus
        logic [PRI_W-1:0] fill_pri [16];
        int               seg_len;
        int               insert_pct;
        int               pri_span;
        int               sent;
        t_kind            kind;
        fill_pri = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd255, 8'd7, 8'd0, 8'd200,
                     8'd128, 8'd1, 8'd254, 8'd64, 8'd64, 8'd255, 8'd3, 8'd100};
        burst_left = $urandom_range(1, 30);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pop on empty, fill with ties and extremes, drop one at full, drain part way.
        send_word(KIND_POP, '0, '0);
        for (int i = 0; i < 16; i++) begin
            send_word(KIND_INSERT, fill_pri[i],
                      (i == 0) ? '1 : (i == 1) ? '0 : PAY_W'($urandom));
        end
        send_word(KIND_INSERT, 8'd255, 32'hA5A5_5A5A);
        repeat (7) send_word(KIND_POP, PRI_W'($urandom), PAY_W'($urandom));

        long_hold_req <= 1'b1;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            seg_len = $urandom_range(10, 80);
            case ($urandom_range(3))
                0:       insert_pct = 20;
                1:       insert_pct = 50;
                2:       insert_pct = 80;
                default: insert_pct = 95;
            endcase
            case ($urandom_range(2))
                0:       pri_span = 3;
                1:       pri_span = 15;
                default: pri_span = 255;
            endcase
            repeat (seg_len) begin
                kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_POP;
                send_word(kind, PRI_W'($urandom_range(pri_span)), PAY_W'($urandom));
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("covered %0d words: %0d inserts, %0d pops", sent_inserts + sent_pops,
                 sent_inserts, sent_pops);
        $display("inserts dropped at full: %0d, pops on empty: %0d", full_drops, empty_pops);
        if (fail_count == 0 && pending == 0) begin
            $display("stable_priority_queue_unit_test: clean");
        end else begin
            $display("stable_priority_queue_unit_test: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("timeout waiting for the queue to drain");
        $display("stable_priority_queue_unit_test: errors");
        $finish;
    end

endmodule
